@@ hw/rtl/zolt_pkg.sv @@
// ----------------------------------------------------------------------------
// zolt_pkg
// Shared types and constants for the z-ordered layer table: command and
// result beats, the stored layer entry, operation and status codes.
// ----------------------------------------------------------------------------
package zolt_pkg;

    localparam int MAX_LAYERS = 16;
    localparam int IDX_W      = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int CNT_W      = $clog2(MAX_LAYERS + 1);
    localparam int LC_W       = 5;

    // layer_count reported once the table is full
    localparam logic [31:0]     MAX_LAYERS_32 = 32'(MAX_LAYERS);
    localparam logic [LC_W-1:0] LC_FULL       = MAX_LAYERS_32[LC_W-1:0];

    localparam logic [2:0] OP_PLACE  = 3'd0;
    localparam logic [2:0] OP_VIS    = 3'd1;
    localparam logic [2:0] OP_FORGET = 3'd2;
    localparam logic [2:0] OP_RAISE  = 3'd3;
    localparam logic [2:0] OP_HIT    = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic [15:0]        client_id;
        logic [15:0]        surface_id;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_w;
        logic [14:0]        rect_h;
        logic               visible_flag;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic               hit_found;
        logic [15:0]        hit_client;
        logic [15:0]        hit_surface;
        logic signed [15:0] hit_left;
        logic signed [15:0] hit_top;
        logic [14:0]        hit_width;
        logic [14:0]        hit_height;
        logic [1:0]         status;
        logic [LC_W-1:0]    layer_count;
    } out_item_t;

    typedef struct packed {
        logic [15:0]        client;
        logic [15:0]        surface;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
        logic               visible;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

endpackage

@@ hw/rtl/z_ordered_layer_table_unit.sv @@
// ----------------------------------------------------------------------------
// z_ordered_layer_table_unit
// Layer table in draw order with place, visibility, forget, raise and
// point hit test, held in one single-port-read synchronous memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------
//  in      | input     | in_valid/in_ready   | in_data  (in_item_t)
//  out     | output    | out_valid/out_ready | out_data (out_item_t)
//
//  One command at a time; a key search or hit test reads one entry per cycle
//  until a match or the end of the table, then responds and returns to idle.
//  Forget and raise add a compaction pass that moves each entry above the
//  index down by one. Unused codes go straight to respond.
//  Reset empties the table at once (entry count to zero); no clearing pass.
//  A new command is taken while the last result waits; respond once out is free.
// ----------------------------------------------------------------------------
module z_ordered_layer_table_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  zolt_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output zolt_pkg::out_item_t out_data
);
    import zolt_pkg::*;

    entry_t mem [MAX_LAYERS];

    state_t             state_reg, state_next;
    in_item_t           cmd_reg, cmd_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   chk_reg, chk_next;
    entry_t             moved_reg, moved_next;
    entry_t             hit_reg, hit_next;
    logic               found_reg, found_next;
    logic [1:0]         status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    entry_t             rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    logic               in_beat;
    logic               out_free;
    logic               scan_done;
    logic               scan_hit;
    logic               key_match;
    logic               pt_inside;
    logic signed [16:0] px, py, left_ext, right_ext, top_ext, bot_ext;
    logic [31:0]        down_off;
    logic [31:0]        total_m1;
    logic [31:0]        total32;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // half-open rectangle test on sign-extended coordinates
    always_comb
    begin
        px        = {cmd_reg.point_x[15], cmd_reg.point_x};
        py        = {cmd_reg.point_y[15], cmd_reg.point_y};
        left_ext  = {rd_data_reg.left[15], rd_data_reg.left};
        top_ext   = {rd_data_reg.top[15], rd_data_reg.top};
        right_ext = left_ext + $signed({2'b00, rd_data_reg.width});
        bot_ext   = top_ext + $signed({2'b00, rd_data_reg.height});
        pt_inside = (px >= left_ext) && (px < right_ext) &&
                    (py >= top_ext) && (py < bot_ext);
    end

    assign key_match = (rd_data_reg.client == cmd_reg.client_id) &&
                       (rd_data_reg.surface == cmd_reg.surface_id);
    assign scan_hit  = (cmd_reg.operation == OP_HIT) ?
                       (rd_data_reg.visible && pt_inside) : key_match;
    assign scan_done = (cnt_reg == total_reg);
    assign total32   = 32'(total_reg);
    assign total_m1  = total32 - 32'd1;
    assign down_off  = total_m1 - 32'(cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        chk_next       = chk_reg;
        moved_next     = moved_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = chk_reg;
        wr_data        = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    cmd_next    = in_data;
                    hit_next    = '0;
                    found_next  = 1'b0;
                    status_next = ST_DONE;
                    cnt_next    = '0;
                    pend_next   = 1'b0;
                    if (in_data.operation <= OP_HIT)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_SCAN:
            begin
                if (pend_reg && scan_hit)
                begin
                    unique case (cmd_reg.operation)
                        OP_PLACE:
                        begin
                            wr_en          = 1'b1;
                            wr_data.left   = cmd_reg.rect_x;
                            wr_data.top    = cmd_reg.rect_y;
                            wr_data.width  = cmd_reg.rect_w;
                            wr_data.height = cmd_reg.rect_h;
                            state_next     = S_RESP;
                        end
                        OP_VIS:
                        begin
                            wr_en           = 1'b1;
                            wr_data.visible = cmd_reg.visible_flag;
                            state_next      = S_RESP;
                        end
                        OP_FORGET, OP_RAISE:
                        begin
                            moved_next = rd_data_reg;
                            cnt_next   = CNT_W'(32'(chk_reg) + 32'd1);
                            pend_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                        OP_HIT:
                        begin
                            hit_next   = rd_data_reg;
                            found_next = 1'b1;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
                else if (scan_done)
                begin
                    // key absent or nothing under the point
                    state_next = S_RESP;
                    if (cmd_reg.operation == OP_PLACE)
                    begin
                        if (total32 >= MAX_LAYERS_32)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = total_reg[IDX_W-1:0];
                            wr_data.client  = cmd_reg.client_id;
                            wr_data.surface = cmd_reg.surface_id;
                            wr_data.left    = cmd_reg.rect_x;
                            wr_data.top     = cmd_reg.rect_y;
                            wr_data.width   = cmd_reg.rect_w;
                            wr_data.height  = cmd_reg.rect_h;
                            wr_data.visible = 1'b1;
                            total_next      = total_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                else
                begin
                    // hit test walks top to bottom, key search bottom to top
                    rd_en = 1'b1;
                    if (cmd_reg.operation == OP_HIT)
                    begin
                        rd_addr = down_off[IDX_W-1:0];
                    end
                    else
                    begin
                        rd_addr = cnt_reg[IDX_W-1:0];
                    end
                    chk_next  = rd_addr;
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end

            S_SHIFT:
            begin
                // read entry i+1 now, write it down to i next cycle
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = chk_reg - 1'b1;
                    wr_data = rd_data_reg;
                end
                if (!scan_done)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = cnt_reg[IDX_W-1:0];
                    chk_next  = cnt_reg[IDX_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_RESP;
                        if (cmd_reg.operation == OP_RAISE)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = total_m1[IDX_W-1:0];
                            wr_data = moved_reg;
                        end
                        else
                        begin
                            total_next = total_reg - 1'b1;
                        end
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.hit_found   = found_reg;
                    out_data_next.hit_client  = hit_reg.client;
                    out_data_next.hit_surface = hit_reg.surface;
                    out_data_next.hit_left    = hit_reg.left;
                    out_data_next.hit_top     = hit_reg.top;
                    out_data_next.hit_width   = hit_reg.width;
                    out_data_next.hit_height  = hit_reg.height;
                    out_data_next.status      = status_reg;
                    out_data_next.layer_count = total32[LC_W-1:0];
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        chk_reg      <= chk_next;
        moved_reg    <= moved_next;
        hit_reg      <= hit_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= MAX_LAYERS_32)
        else $error("entry count beyond table depth");

    a_shift_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |->
        (cmd_reg.operation == OP_FORGET || cmd_reg.operation == OP_RAISE))
        else $error("compaction entered for an operation that keeps order");

    a_shift_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("compaction reads and writes the same entry");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_FULL) |-> (out_data.layer_count == LC_FULL))
        else $error("table full reported below full count");

    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.hit_found) |-> (out_data.status == ST_DONE))
        else $error("hit reported with failure status");

endmodule
